// ===== hdl/wmde_pkg.sv =====
// Shared types and constants for the WOTS+ message digit encoder.
package wmde_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	typedef enum logic [0:0] {
		REG_W_SELECT    = 1'b0,
		REG_DIGEST_SIZE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic w16;
		logic dsz64;
	} wmde_cfg_t;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       w16;
		logic       last;
		logic [8:0] base_idx;
		logic [8:0] len1;
	} wmde_entry_t;

endpackage

// ===== hdl/wmde_ifs.sv =====
// Channel interfaces for digest bytes in and encoded digits out.
interface wmde_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;

	modport source (output valid, output msg_byte, input ready);
	modport sink (input valid, input msg_byte, output ready);
endinterface

interface wmde_dig_if;
	logic       valid;
	logic       ready;
	logic [3:0] digit;
	logic [3:0] remaining_steps;
	logic [8:0] chain_index;
	logic       is_checksum;
	logic       end_of_run;
	logic       end_of_message;

	modport source (output valid, output digit, output remaining_steps, output chain_index,
		output is_checksum, output end_of_run, output end_of_message, input ready);
	modport sink (input valid, input digit, input remaining_steps, input chain_index,
		input is_checksum, input end_of_run, input end_of_message, output ready);
endinterface

// ===== hdl/wmde_front.sv =====
// Front end: byte counter and per-byte classification into queue entries.
module wmde_front import wmde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	wmde_msg_if.sink    msg,
	input  wmde_cfg_t   cfg,
	output logic        push_valid,
	input  logic        push_ready,
	output wmde_entry_t push_entry
);

	logic [6:0] byte_count_q;
	logic       last_byte;
	logic       accept;

	assign msg.ready  = push_ready;
	assign push_valid = msg.valid;
	assign accept     = msg.valid && push_ready;

	always_comb begin
		last_byte = ({1'b0, byte_count_q} + 8'd1) >= (cfg.dsz64 ? 8'd64 : 8'd32);
		push_entry.msg_byte = msg.msg_byte;
		push_entry.w16      = cfg.w16;
		push_entry.last     = last_byte;
		push_entry.base_idx = cfg.w16 ? {1'b0, byte_count_q, 1'b0} : {byte_count_q, 2'b00};
		case ({cfg.dsz64, cfg.w16})
			2'b00:   push_entry.len1 = 9'd128;
			2'b01:   push_entry.len1 = 9'd64;
			2'b10:   push_entry.len1 = 9'd256;
			2'b11:   push_entry.len1 = 9'd128;
			default: push_entry.len1 = 9'd128;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 7'd0;
		end else if (accept) begin
			byte_count_q <= last_byte ? 7'd0 : byte_count_q + 7'd1;
		end
	end

endmodule

// ===== hdl/wmde_queue.sv =====
// Short FIFO between front end and digit sequencer.
module wmde_queue import wmde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  wmde_entry_t push_entry,
	output logic        pop_valid,
	input  logic        pop_ready,
	output wmde_entry_t pop_entry
);

	wmde_entry_t         mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = count_q != QUEUE_CW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/wmde_back.sv =====
// Back end: emits one digit per cycle while the output is not stalled, tracks checksum, appends checksum digits.
module wmde_back import wmde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  wmde_entry_t pop_entry,
	wmde_dig_if.source  dig
);

	wmde_entry_t cur_q;
	logic        busy_q;
	logic [3:0]  step_q;
	logic [10:0] csum_q;

	logic        ovalid_q;
	logic [3:0]  digit_q;
	logic [3:0]  rem_q;
	logic [8:0]  idx_q;
	logic        is_cs_q;
	logic        eor_q;
	logic        eom_q;

	logic        advance;
	logic [3:0]  n_msg;
	logic [3:0]  n_tot;
	logic        is_cs;
	logic        final_step;
	logic [3:0]  j;
	logic [7:0]  sh_byte;
	logic [11:0] cs16;
	logic [9:0]  cs4;
	logic [3:0]  wm1;
	logic [3:0]  digit_n;
	logic [3:0]  rem_n;
	logic [8:0]  idx_n;

	always_comb begin
		advance    = busy_q && (!ovalid_q || dig.ready);
		n_msg      = cur_q.w16 ? 4'd2 : 4'd4;
		n_tot      = n_msg + (cur_q.last ? (cur_q.w16 ? 4'd3 : 4'd5) : 4'd0);
		is_cs      = step_q >= n_msg;
		final_step = step_q == (n_tot - 4'd1);
		j          = step_q - n_msg;
		sh_byte    = 8'(cur_q.msg_byte << (cur_q.w16 ? {step_q[1:0], 2'b00}
			: {1'b0, step_q[1:0], 1'b0}));
		cs16       = 12'({1'b0, csum_q} << {j[1:0], 2'b00});
		cs4        = 10'(csum_q[9:0] << {j[2:0], 1'b0});
		wm1        = cur_q.w16 ? 4'd15 : 4'd3;
		if (is_cs) begin
			digit_n = cur_q.w16 ? cs16[11:8] : {2'b00, cs4[9:8]};
			idx_n   = cur_q.len1 + {5'd0, j};
		end else begin
			digit_n = cur_q.w16 ? sh_byte[7:4] : {2'b00, sh_byte[7:6]};
			idx_n   = cur_q.base_idx + {5'd0, step_q};
		end
		rem_n     = wm1 - digit_n;
		pop_ready = !busy_q || (advance && final_step);
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_entry;
		end
		if (advance) begin
			digit_q <= digit_n;
			rem_q   <= rem_n;
			idx_q   <= idx_n;
			is_cs_q <= is_cs;
			eor_q   <= final_step;
			eom_q   <= final_step && cur_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= 4'd0;
			csum_q   <= 11'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
				step_q <= 4'd0;
			end else if (advance && final_step) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				step_q <= step_q + 4'd1;
			end
			if (advance && !is_cs) begin
				csum_q <= csum_q + {7'd0, rem_n};
			end else if (advance && final_step && cur_q.last) begin
				csum_q <= 11'd0;
			end
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (dig.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign dig.valid           = ovalid_q;
	assign dig.digit           = digit_q;
	assign dig.remaining_steps = rem_q;
	assign dig.chain_index     = idx_q;
	assign dig.is_checksum     = is_cs_q;
	assign dig.end_of_run      = eor_q;
	assign dig.end_of_message  = eom_q;

	a_eom_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && eom_q |-> eor_q && is_cs_q)
		else $error("end of message without end of run on checksum digit");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q < 4'd9)
		else $error("digit step out of range");

	a_csum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && final_step && cur_q.last |=> csum_q == 11'd0)
		else $error("checksum not cleared after message");

endmodule

// ===== hdl/wots_message_digit_encoder.sv =====
// Top level: WOTS+ base-w message digit encoder with checksum and APB config.
// Path: an accepted byte passes the queue into the sequencer's entry register; its digits leave registered.
// Throughput: one digit per cycle from the sequencer while the output is not stalled, with 2 digits per byte
// at w=16 and 4 at w=4; the last byte of a message adds 3 (w=16) or 5 (w=4) checksum digits.
// A 2-entry queue lets bytes be taken while the sequencer and output register are busy.
// Reset: arst_n clears byte count, checksum, queue and output valid; w_select=1, size=32.
module wots_message_digit_encoder import wmde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	wmde_msg_if.sink          msg,
	wmde_dig_if.source        dig,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	wmde_cfg_t   cfg_q;
	reg_idx_t    reg_idx;
	logic        push_valid;
	logic        push_ready;
	wmde_entry_t push_entry;
	logic        pop_valid;
	logic        pop_ready;
	wmde_entry_t pop_entry;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.w16   <= 1'b1;
			cfg_q.dsz64 <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_W_SELECT:    cfg_q.w16   <= pwdata[0];
				REG_DIGEST_SIZE: cfg_q.dsz64 <= pwdata[0];
				default:         cfg_q       <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_W_SELECT:    prdata = {{(APB_DW - 1){1'b0}}, cfg_q.w16};
			REG_DIGEST_SIZE: prdata = {{(APB_DW - 1){1'b0}}, cfg_q.dsz64};
			default:         prdata = '0;
		endcase
	end

	wmde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	wmde_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	wmde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.dig       (dig)
	);

endmodule

// ===== bench/wots_message_digit_encoder_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the WOTS+ digit encoder: byte stream in, scoreboarded digits out.
module wots_message_digit_encoder_test;
	import wmde_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_BYTES  = 255;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [3:0] digit;
		logic [3:0] remaining_steps;
		logic [8:0] chain_index;
		logic       is_checksum;
		logic       end_of_run;
		logic       end_of_message;
	} digit_beat_t;

	typedef enum int {
		PAT_RANDOM,
		PAT_ZERO,
		PAT_ONES,
		PAT_CORNER
	} byte_pattern_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              byte_valid  = 1'b0;
	logic [7:0]        byte_data   = '0;
	logic              digit_ready = 1'b0;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [APB_AW-1:0] paddr       = '0;
	logic [APB_DW-1:0] pwdata      = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	wmde_msg_if msg_ch ();
	wmde_dig_if dig_ch ();

	assign msg_ch.valid    = byte_valid;
	assign msg_ch.msg_byte = byte_data;
	assign dig_ch.ready    = digit_ready;

	logic [7:0]  byte_backlog[$];
	digit_beat_t digit_forecast[$];
	int unsigned bytes_queued = 0;
	int unsigned bytes_taken  = 0;
	int unsigned err_count    = 0;
	int unsigned cycle_count  = 0;
	int unsigned idle_pct     = 0;
	int unsigned stall_pct    = 0;

	// encoder state as the bench sees it
	logic        cur_w16    = 1'b1;
	logic        cur_dsz64  = 1'b0;
	logic [6:0]  pos_in_msg = '0;
	logic [10:0] csum_acc   = '0;

	wots_message_digit_encoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg_ch),
		.dig     (dig_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("wots_message_digit_encoder: mismatch");
			$finish;
		end
	end

	function automatic void encode_byte(input logic [7:0] msg_byte);
		digit_beat_t run [9];
		int unsigned bits, wm1, per_byte, n_bytes, len2, n;
		logic [8:0]  len1;
		bits     = cur_w16 ? 4 : 2;
		wm1      = cur_w16 ? 15 : 3;
		per_byte = 8 / bits;
		n_bytes  = cur_dsz64 ? 64 : 32;
		len1     = 9'(n_bytes * per_byte);
		len2     = cur_w16 ? 3 : 5;
		n        = 0;
		for (int k = 0; k < per_byte; k++) begin
			run[n]                 = '0;
			run[n].digit           = 4'((msg_byte >> (8 - bits * (k + 1))) & wm1);
			run[n].remaining_steps = 4'(wm1) - run[n].digit;
			run[n].chain_index     = 9'(int'(pos_in_msg) * per_byte + k);
			csum_acc               = 11'(csum_acc + run[n].remaining_steps);
			n++;
		end
		if (int'(pos_in_msg) + 1 >= n_bytes) begin
			// checksum tail, most significant digit first
			for (int k = 0; k < len2; k++) begin
				run[n]                 = '0;
				run[n].digit           = 4'((csum_acc >> (bits * (len2 - 1 - k))) & wm1);
				run[n].remaining_steps = 4'(wm1) - run[n].digit;
				run[n].chain_index     = len1 + 9'(k);
				run[n].is_checksum     = 1'b1;
				n++;
			end
			run[n - 1].end_of_message = 1'b1;
			pos_in_msg = '0;
			csum_acc   = '0;
		end else begin
			pos_in_msg = pos_in_msg + 7'd1;
		end
		run[n - 1].end_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			digit_forecast.push_back(run[i]);
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			err_count++;
		end
	endfunction

	function automatic void check_digit();
		digit_beat_t want;
		if (digit_forecast.size() == 0) begin
			$error("chain_index: expected no beat, got %0d", dig_ch.chain_index);
			err_count++;
			return;
		end
		want = digit_forecast.pop_front();
		compare_field("digit", want.digit, dig_ch.digit);
		compare_field("remaining_steps", want.remaining_steps, dig_ch.remaining_steps);
		compare_field("chain_index", want.chain_index, dig_ch.chain_index);
		compare_field("is_checksum", want.is_checksum, dig_ch.is_checksum);
		compare_field("end_of_run", want.end_of_run, dig_ch.end_of_run);
		compare_field("end_of_message", want.end_of_message, dig_ch.end_of_message);
	endfunction

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data  <= '0;
		end else begin
			if (byte_valid && msg_ch.ready) begin
				encode_byte(byte_data);
				bytes_taken++;
			end
			if (!byte_valid || msg_ch.ready) begin
				if (byte_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
					byte_valid <= 1'b1;
					byte_data  <= byte_backlog.pop_front();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// digit monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_ready <= 1'b0;
		end else begin
			if (dig_ch.valid && digit_ready)
				check_digit();
			digit_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [7:0] corner_byte(input int unsigned i);
		case (i)
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h0F;
			3:       return 8'hF0;
			4:       return 8'hA5;
			5:       return 8'h5A;
			6:       return 8'h3C;
			7:       return 8'hC3;
			8:       return 8'h01;
			default: return 8'h80;
		endcase
	endfunction

	function automatic void push_byte(input logic [7:0] value);
		byte_backlog.push_back(value);
		bytes_queued++;
	endfunction

	function automatic void queue_bytes(input int unsigned count, input byte_pattern_t pattern);
		for (int i = 0; i < count; i++) begin
			case (pattern)
				PAT_ZERO:   push_byte(8'h00);
				PAT_ONES:   push_byte(8'hFF);
				PAT_CORNER: push_byte(corner_byte($urandom_range(9)));
				default:    push_byte(8'($urandom));
			endcase
		end
	endfunction

	task automatic wait_drained();
		while (bytes_taken != bytes_queued || digit_forecast.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write, then read back; called on a clock edge with the encoder idle
	task automatic write_reg(input reg_idx_t idx, input logic value, input string name);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_W_SELECT)
			cur_w16 = value;
		else
			cur_dsz64 = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		compare_field(name, APB_DW'(value), prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned   n_bytes;
		int unsigned   remaining;
		int unsigned   count;
		int unsigned   random_start;
		byte_pattern_t pattern;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_W_SELECT, 1'b1, "w_select");
		write_reg(REG_DIGEST_SIZE, 1'b0, "digest_size_select");
		for (int i = 0; i < 10; i++)
			push_byte(corner_byte(i));
		wait_drained();
		// w changes inside a message
		write_reg(REG_W_SELECT, 1'b0, "w_select");
		for (int i = 0; i < 4; i++)
			push_byte(corner_byte(i));
		wait_drained();
		// long zero run at w=16 drives the sum past 10 bits
		write_reg(REG_W_SELECT, 1'b1, "w_select");
		write_reg(REG_DIGEST_SIZE, 1'b1, "digest_size_select");
		queue_bytes(30, PAT_ZERO);
		wait_drained();
		// size shrink past the current position: next byte closes the message at w=4
		write_reg(REG_W_SELECT, 1'b0, "w_select");
		write_reg(REG_DIGEST_SIZE, 1'b0, "digest_size_select");
		push_byte(8'hFF);
		wait_drained();

		random_start = bytes_queued;
		for (int ph = 0; bytes_queued - random_start < RANDOM_BYTES; ph++) begin
			write_reg(REG_W_SELECT, ph[0], "w_select");
			write_reg(REG_DIGEST_SIZE, ph[1] ^ ph[2], "digest_size_select");
			case ((ph < 4) ? ph : $urandom_range(3))
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 65;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 65;
				end
				default: begin
					idle_pct  = 17;
					stall_pct = 17;
				end
			endcase
			n_bytes   = cur_dsz64 ? 64 : 32;
			remaining = (pos_in_msg >= n_bytes) ? 1 : n_bytes - pos_in_msg;
			count     = remaining;
			if ($urandom_range(3) == 0)
				count = $urandom_range(remaining, 1);
			else if ($urandom_range(2) == 0)
				count = remaining + n_bytes;
			case ($urandom_range(9))
				0:       pattern = PAT_ZERO;
				1:       pattern = PAT_ONES;
				2, 3:    pattern = PAT_CORNER;
				default: pattern = PAT_RANDOM;
			endcase
			queue_bytes(count, pattern);
			wait_drained();
		end

		if (err_count == 0)
			$display("wots_message_digit_encoder: match");
		else
			$display("wots_message_digit_encoder: mismatch");
		$finish;
	end

endmodule
